@@ sv/dspm_pkg.sv @@
// shared types and constants for the dual serial port with mouse
// no dependencies
package dspm_pkg;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 8;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] PORT_A_DATA = 2'd0;
	localparam logic [1:0] PORT_A_CTRL = 2'd1;
	localparam logic [1:0] PORT_B_DATA = 2'd2;
	localparam logic [1:0] PORT_B_CTRL = 2'd3;

	localparam logic [2:0] REG_NONE     = 3'd0;
	localparam logic [2:0] REG_RX_CTRL  = 3'd3;
	localparam logic [2:0] REG_TX_CTRL  = 3'd5;
	localparam int         RTS_BIT      = 1;
	localparam int         TX_COUNT_BIT = 3;
	localparam logic [7:0] PTR_MASK_A   = 8'hf1;

	localparam logic [7:0] STAT_RX_AVAIL = 8'h01;
	localparam logic [7:0] STAT_TX_EMPTY = 8'h04;

	localparam logic [7:0] FLAG_X_HIGH = 8'h10;
	localparam logic [7:0] FLAG_X_LOW  = 8'h20;
	localparam logic [7:0] FLAG_Y_HIGH = 8'h40;
	localparam logic [7:0] FLAG_Y_LOW  = 8'h80;
	localparam logic [7:0] AXIS_MAX    = 8'h7f;
	localparam logic [7:0] AXIS_MIN    = 8'h80;
	localparam logic signed [15:0] AXIS_LIMIT = 16'sd127;

	localparam logic [1:0] PUSH_HDR  = 2'd0;
	localparam logic [1:0] PUSH_X    = 2'd1;
	localparam logic [1:0] PUSH_LAST = 2'd2;

	// last field in the lowest bits
	typedef struct packed {
		logic signed [15:0] mouse_dy;
		logic signed [15:0] mouse_dx;
		logic [1:0]         mouse_buttons;
		logic [7:0]         write_data;
		logic [1:0]         port_offset;
		logic               operation;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	typedef struct packed {
		logic [7:0] hdr;
		logic [7:0] x;
		logic [7:0] y;
	} mouse_pkt_t;

endpackage

@@ sv/dspm_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module dspm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ sv/dspm_mouse.sv @@
// mouse sample formatter: button header with overflow flags, saturated axes
// depends on dspm_pkg
module dspm_mouse (
	input  logic [1:0]              buttons,
	input  logic signed [15:0]      dx,
	input  logic signed [15:0]      dy,
	output dspm_pkg::mouse_pkt_t    pkt
);
	import dspm_pkg::*;

	logic [7:0] flags;

	always_comb begin
		flags = {6'd0, buttons};
		if (dx > AXIS_LIMIT) begin
			flags = flags | FLAG_X_HIGH;
			pkt.x = AXIS_MAX;
		end else if (dx < -AXIS_LIMIT) begin
			flags = flags | FLAG_X_LOW;
			pkt.x = AXIS_MIN;
		end else begin
			pkt.x = dx[7:0];
		end
		if (dy > AXIS_LIMIT) begin
			flags = flags | FLAG_Y_HIGH;
			pkt.y = AXIS_MAX;
		end else if (dy < -AXIS_LIMIT) begin
			flags = flags | FLAG_Y_LOW;
			pkt.y = AXIS_MIN;
		end else begin
			pkt.y = dy[7:0];
		end
		pkt.hdr = flags;
	end
endmodule

@@ sv/dual_serial_port_with_mouse.sv @@
// top level of the dual serial port with mouse: register file, fifo control
// depends on dspm_pkg, dspm_ram, dspm_mouse
//
// Each input transfer is one bus access (read or write on one of four ports).
// Each input transfer gives exactly one output transfer carrying the byte read
// (zero for writes). Items are taken into an input register, decoded there,
// and the answer goes into an output register; a data read of channel B
// that finds data in the fifo fetches its byte from the receive fifo ram,
// whose registered read port feeds the output mux.
// An access passes the input register and then the output register before
// m_tvalid rises; a write that samples the mouse waits in the input register.
// Throughput: one access per cycle while m_tready allows; a channel B register
// 5 write that raises rts holds the input register while the three-byte mouse
// packet is written to the fifo ram, one byte per cycle through its single
// write port while the output register is free.
// Reset clears all write registers, register pointers, fifo head and count
// and the transmit count; the fifo ram itself is not cleared and needs no
// clearing pass since the count tells which entries hold data.
// When m_tready is low the output register holds its byte, the input register
// holds the next access, and s_tready drops once both are full.
module dual_serial_port_with_mouse #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// operation, port_offset, write_data, mouse_buttons, mouse_dx, mouse_dy, zero pad
	input  logic [dspm_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_data
	output logic [dspm_pkg::M_TDATA_W-1:0]   m_tdata
);
	import dspm_pkg::*;

	localparam int              AW       = $clog2(FIFO_DEPTH);
	localparam logic [AW:0]     DEPTH_W  = (AW+1)'(FIFO_DEPTH);
	localparam logic [AW-1:0]   LAST_IDX = AW'(FIFO_DEPTH - 1);

	item_t        item_s1;
	logic         valid_s1;
	logic         valid_s2;
	logic         from_ram_s2;
	logic [7:0]   data_s2;
	logic [1:0]   push_q;

	logic [7:0]    a_regs_q [8];
	logic [2:0]    a_ptr_q;
	logic [AW-1:0] a_tx_cnt_q;
	logic [7:0]    b_regs_q [8];
	logic [2:0]    b_ptr_q;
	logic [AW-1:0] b_head_q;
	logic [AW-1:0] b_cnt_q;

	mouse_pkt_t    pkt;
	logic          is_wr;
	logic          trigger;
	logic          s2_free;
	logic          adv;
	logic          push_we;
	logic          pop;
	logic [AW:0]   waddr_sum;
	logic [AW-1:0] waddr;
	logic [7:0]    wbyte;
	logic [7:0]    imm;
	logic [7:0]    ram_rdata;

	dspm_mouse u_mouse (
		.buttons (item_s1.mouse_buttons),
		.dx      (item_s1.mouse_dx),
		.dy      (item_s1.mouse_dy),
		.pkt     (pkt)
	);

	dspm_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_b_rx_ram (
		.clk   (clk),
		.we    (push_we),
		.waddr (waddr),
		.wdata (wbyte),
		.re    (adv && pop),
		.raddr (b_head_q),
		.rdata (ram_rdata)
	);

	assign is_wr   = item_s1.operation == OP_WRITE;
	assign trigger = valid_s1 && is_wr && item_s1.port_offset == PORT_B_CTRL &&
		b_ptr_q == REG_TX_CTRL && !b_regs_q[REG_TX_CTRL][RTS_BIT] &&
		item_s1.write_data[RTS_BIT];
	assign s2_free = !valid_s2 || m_tready;
	assign adv     = valid_s1 && s2_free && (!trigger || push_q == PUSH_LAST);
	assign push_we = trigger && s2_free;
	assign pop     = valid_s1 && !is_wr && item_s1.port_offset == PORT_B_DATA &&
		b_cnt_q != '0;
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = from_ram_s2 ? ram_rdata : data_s2;

	// fifo write position: head plus count, wrapped
	always_comb begin
		waddr_sum = {1'b0, b_head_q} + {1'b0, b_cnt_q};
		if (waddr_sum >= DEPTH_W) begin
			waddr_sum = waddr_sum - DEPTH_W;
		end
		waddr = waddr_sum[AW-1:0];
	end

	always_comb begin
		case (push_q)
			PUSH_HDR: wbyte = pkt.hdr;
			PUSH_X:   wbyte = pkt.x;
			default:  wbyte = pkt.y;
		endcase
	end

	always_comb begin
		imm = 8'd0;
		if (!is_wr) begin
			case (item_s1.port_offset)
				PORT_A_CTRL: begin
					if (a_ptr_q == REG_NONE && a_tx_cnt_q == '0) begin
						imm = STAT_TX_EMPTY;
					end
				end
				PORT_B_CTRL: begin
					if (b_ptr_q == REG_NONE) begin
						imm = STAT_TX_EMPTY | ((b_cnt_q != '0) ? STAT_RX_AVAIL : 8'd0);
					end
				end
				default: imm = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			from_ram_s2 <= pop;
			data_s2     <= imm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_q     <= PUSH_HDR;
			a_ptr_q    <= REG_NONE;
			a_tx_cnt_q <= '0;
			b_ptr_q    <= REG_NONE;
			b_head_q   <= '0;
			b_cnt_q    <= '0;
			for (int i = 0; i < 8; i++) begin
				a_regs_q[i] <= 8'd0;
				b_regs_q[i] <= 8'd0;
			end
		end else begin
			if (push_we) begin
				push_q  <= adv ? PUSH_HDR : push_q + 2'd1;
				b_cnt_q <= (b_cnt_q == LAST_IDX) ? '0 : b_cnt_q + AW'(1);
			end
			if (adv) begin
				if (is_wr) begin
					case (item_s1.port_offset)
						PORT_A_DATA: begin
							if (a_regs_q[REG_RX_CTRL][TX_COUNT_BIT]) begin
								a_tx_cnt_q <= (a_tx_cnt_q == LAST_IDX) ? '0 :
									a_tx_cnt_q + AW'(1);
							end
						end
						PORT_A_CTRL: begin
							a_regs_q[a_ptr_q] <= item_s1.write_data;
							if (a_ptr_q != REG_NONE) begin
								a_ptr_q <= REG_NONE;
							end else if ((item_s1.write_data & PTR_MASK_A) != 8'd0) begin
								a_ptr_q <= item_s1.write_data[2:0];
							end
						end
						PORT_B_CTRL: begin
							b_regs_q[b_ptr_q] <= item_s1.write_data;
							b_ptr_q <= (b_ptr_q != REG_NONE) ? REG_NONE :
								item_s1.write_data[2:0];
						end
						default: ;
					endcase
				end else if (pop) begin
					b_cnt_q  <= b_cnt_q - AW'(1);
					b_head_q <= (b_head_q == LAST_IDX) ? '0 : b_head_q + AW'(1);
				end
			end
		end
	end
endmodule
